// ===== design/pva_pkg.sv =====
// Package with shared types and constants of the priority voice allocator.
`timescale 1ns / 1ps
package pva_pkg;

  localparam int unsigned MAX_CHANNELS_DEF = 8;

  localparam logic [2:0] CMD_START  = 3'd0;
  localparam logic [2:0] CMD_QUERY  = 3'd1;
  localparam logic [2:0] CMD_STOP   = 3'd2;
  localparam logic [2:0] CMD_VOLUME = 3'd3;
  localparam logic [2:0] CMD_UPDATE = 3'd4;

  localparam logic       STATUS_OK      = 1'b0;
  localparam logic       STATUS_REFUSED = 1'b1;

  localparam logic signed [31:0] PRIO_FREE = 32'sh8000_0000;
  localparam logic [7:0] VOL_MAX       = 8'd255;
  localparam logic [7:0] STEP_NO_NOTE  = 8'd8;
  localparam logic [7:0] STEP_OFFSET   = 8'd2;
  localparam logic [7:0] STEP_STOPPED  = 8'd1;

  // One input word.
  typedef struct packed {
    logic [2:0]         command;
    logic               any_channel;
    logic [3:0]         channel_number;
    logic [7:0]         effect_id;
    logic signed [31:0] request_priority;
    logic               note_given;
    logic [11:0]        note_value;
    logic [15:0]        volume_value;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic       status_code;
    logic [3:0] chosen_channel;
    logic [7:0] reported_id;
    logic [7:0] step_code;
    logic [4:0] fine_note;
    logic       pitch_driven;
  } out_word_t;

  // One channel entry as held in the channel memory.
  typedef struct packed {
    logic signed [31:0] prio;
    logic [7:0]         effect;
    logic [7:0]         step;
    logic [4:0]         fine;
    logic               pflag;
    logic [7:0]         vol;
    logic [7:0]         mix;
  } chan_t;

  localparam chan_t CHAN_RESET = '{prio: PRIO_FREE, default: '0};

endpackage

// ===== design/pva_in_if.sv =====
// Valid/ready channel interface carrying input words.
`timescale 1ns / 1ps
interface pva_in_if import pva_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/pva_out_if.sv =====
// Valid/ready channel interface carrying result words.
`timescale 1ns / 1ps
interface pva_out_if import pva_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/priority_voice_allocator.sv =====
// Top level of the priority voice allocator: register port, sequencer, channel memory.
//
//   Port      Dir  Handshake            Word
//   in_i      in   valid/ready          command request (in_word_t)
//   out_o     out  valid/ready          one result per command (out_word_t)
//   psel..    in   APB write/read       channels_in_use at byte address 0
//
// For each channel it touches, a command passes a memory read (S_RD), then a modify
// and write-back state (S_EX), besides entry (S_IDLE) and result hand-off (S_RES);
// a priority start scans up to MaxChannels entries and then rereads the winner. The
// single memory port serializes these steps. One command is in work at a time; the
// result register lets the next word be taken while a result waits.
// Reset clears control state and marks all channel entries free; no clearing pass.
`timescale 1ns / 1ps
module priority_voice_allocator import pva_pkg::*; #(
  parameter int unsigned MaxChannels = MAX_CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pva_in_if.sink      in_i,
  pva_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;

  logic [3:0]    chans_q;
  logic          ram_we;
  logic          ram_re;
  logic [IW-1:0] ram_addr;
  chan_t         ram_wdata;
  chan_t         ram_rdata;

  // Configuration register write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chans_q <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      chans_q <= pwdata[3:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {28'd0, chans_q};

  // Command sequencer.
  pva_ctrl #(.MaxChannels(MaxChannels)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_i),
    .out_if      (out_o),
    .used_cnt_i  (chans_q),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  // Channel table memory.
  pva_ram #(.Width($bits(chan_t)), .Depth(MaxChannels)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== design/pva_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module pva_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port share one address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pva_ctrl.sv =====
// Command sequencer: reads, modifies and writes back channel entries.
`timescale 1ns / 1ps
module pva_ctrl import pva_pkg::*; #(
  parameter int unsigned MaxChannels = MAX_CHANNELS_DEF,
  localparam int unsigned IW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1,
  localparam int unsigned NW = $clog2(MaxChannels + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pva_in_if.sink        in_if,
  pva_out_if.source     out_if,
  input  logic [3:0]    used_cnt_i,
  output logic          ram_we_o,
  output logic          ram_re_o,
  output logic [IW-1:0] ram_addr_o,
  output chan_t         ram_wdata_o,
  input  chan_t         ram_rdata_i
);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_EX, S_RES} state_e;

  localparam logic [4:0] MAX_W = 5'(MaxChannels);

  state_e             state_q, state_d;
  in_word_t           req_q, req_d;
  logic [NW-1:0]      n_q, n_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [IW-1:0]      sel_q, sel_d;
  logic signed [31:0] best_q, best_d;
  logic               found_q, found_d;
  logic               final_q, final_d;
  out_word_t          res_q, res_d;
  out_word_t          out_q, out_d;
  logic               ovalid_q, ovalid_d;
  logic [MaxChannels-1:0] vld_q, vld_d;

  logic [4:0]   cfg_w;
  logic [4:0]   n_now;
  chan_t        cur;
  chan_t        wword;
  logic         last;
  logic         le;
  logic [7:0]   vol_c;
  logic [7:0]   step_c;
  logic [4:0]   fine_c;
  logic         slot_free;

  // Usable channel count, limited by the channel memory depth.
  assign cfg_w = {1'b0, used_cnt_i};
  assign n_now = (cfg_w > MAX_W) ? MAX_W : cfg_w;

  // An entry never written reads as its reset value.
  assign cur  = vld_q[idx_q] ? ram_rdata_i : CHAN_RESET;
  assign last = ((NW + 1)'(idx_q) + (NW + 1)'(1)) == (NW + 1)'(n_q);
  assign le   = cur.prio <= best_q;

  // Start values derived from the request.
  assign vol_c  = (req_q.volume_value > 16'(VOL_MAX)) ? VOL_MAX : req_q.volume_value[7:0];
  assign step_c = req_q.note_given ? ({1'b0, req_q.note_value[11:5]} + STEP_OFFSET)
                                   : STEP_NO_NOTE;
  assign fine_c = req_q.note_given ? req_q.note_value[4:0] : 5'd0;

  assign slot_free = !ovalid_q || out_if.ready;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    n_d      = n_q;
    idx_d    = idx_q;
    sel_d    = sel_q;
    best_d   = best_q;
    found_d  = found_q;
    final_d  = final_q;
    res_d    = res_q;
    out_d    = out_q;
    ovalid_d = ovalid_q && !out_if.ready;
    vld_d    = vld_q;
    wword    = cur;
    ram_we_o = 1'b0;
    ram_re_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_if.valid) begin
          req_d   = in_if.data;
          n_d     = NW'(n_now);
          best_d  = in_if.data.request_priority;
          found_d = 1'b0;
          sel_d   = '0;
          final_d = 1'b0;
          res_d   = '0;
          res_d.status_code = STATUS_REFUSED;
          state_d = S_RES;
          if (in_if.data.command > CMD_UPDATE) begin
            state_d = S_RES;
          end else if (in_if.data.any_channel) begin
            if (in_if.data.command == CMD_QUERY) begin
              state_d = S_RES;
            end else if (n_now == 5'd0) begin
              if (in_if.data.command != CMD_START) begin
                res_d.status_code = STATUS_OK;
              end
            end else begin
              idx_d   = '0;
              state_d = S_RD;
            end
          end else if ({1'b0, in_if.data.channel_number} < n_now) begin
            idx_d   = in_if.data.channel_number[IW-1:0];
            state_d = S_RD;
          end
        end
      end

      S_RD: begin
        ram_re_o = 1'b1;
        state_d  = S_EX;
      end

      S_EX: begin
        state_d = S_RES;
        case (req_q.command)
          CMD_START: begin
            if (req_q.any_channel && !final_q) begin
              // Priority scan: last entry at or below the running best wins.
              if (le) begin
                best_d  = cur.prio;
                sel_d   = idx_q;
                found_d = 1'b1;
              end
              if (!last) begin
                idx_d   = idx_q + IW'(1);
                state_d = S_RD;
              end else if (le || found_q) begin
                idx_d   = le ? idx_q : sel_q;
                final_d = 1'b1;
                state_d = S_RD;
              end
            end else if (final_q || !(req_q.request_priority < cur.prio)) begin
              wword.prio   = req_q.request_priority;
              wword.effect = req_q.effect_id;
              wword.step   = step_c;
              wword.fine   = fine_c;
              wword.pflag  = req_q.note_given;
              wword.vol    = vol_c;
              ram_we_o     = 1'b1;
              vld_d[idx_q] = 1'b1;
              res_d.status_code    = STATUS_OK;
              res_d.chosen_channel = 4'(idx_q);
              res_d.reported_id    = req_q.effect_id;
              res_d.step_code      = step_c;
              res_d.fine_note      = fine_c;
              res_d.pitch_driven   = req_q.note_given;
            end
          end
          CMD_QUERY: begin
            // A free channel forgets its effect id.
            if (cur.prio == PRIO_FREE) begin
              wword.effect = '0;
            end
            ram_we_o     = 1'b1;
            vld_d[idx_q] = 1'b1;
            res_d.status_code    = STATUS_OK;
            res_d.chosen_channel = 4'(idx_q);
            res_d.reported_id    = wword.effect;
          end
          CMD_STOP, CMD_VOLUME, CMD_UPDATE: begin
            if (req_q.command == CMD_STOP) begin
              wword.step = STEP_STOPPED;
            end else if (req_q.command == CMD_VOLUME) begin
              wword.mix = vol_c;
            end else begin
              wword.prio = req_q.request_priority;
            end
            ram_we_o     = 1'b1;
            vld_d[idx_q] = 1'b1;
            if (req_q.any_channel && !last) begin
              idx_d   = idx_q + IW'(1);
              state_d = S_RD;
            end else begin
              res_d.status_code    = STATUS_OK;
              res_d.chosen_channel = req_q.any_channel ? 4'd0 : 4'(idx_q);
            end
          end
          default: begin
            state_d = S_RES;
          end
        endcase
      end

      S_RES: begin
        if (slot_free) begin
          out_d    = res_q;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      vld_q    <= '0;
      final_q  <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      vld_q    <= vld_d;
      final_q  <= final_d;
      found_q  <= found_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    n_q    <= n_d;
    idx_q  <= idx_d;
    sel_q  <= sel_d;
    best_q <= best_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign in_if.ready  = (state_q == S_IDLE);
  assign out_if.valid = ovalid_q;
  assign out_if.data  = out_q;
  assign ram_addr_o   = idx_q;
  assign ram_wdata_o  = wword;

endmodule
